FILE: rtl/core/tph_pkg.sv
`timescale 1ns / 1ps
package tph_pkg;

   localparam int COORD_BITS = 16;
   localparam int QW         = 32;
   localparam int SCALE_W    = 24;
   // edge vector, normal and scaled query offset widths
   localparam int EDGE_W     = COORD_BITS + 1;
   localparam int NORM_W     = 2 * EDGE_W + 1;
   localparam int DQ_W       = QW + SCALE_W + 1;
   // query offset is multiplied in two halves split at this bit
   localparam int SPLIT_W    = 29;
   localparam int NUM_W      = DQ_W + NORM_W + 2;
   localparam int DEN_W      = NORM_W + SCALE_W + 1;
   localparam int QUO_W      = NUM_W;
   localparam int ADDR_W     = 1;

   typedef enum logic [ADDR_W-1:0] {
      REG_LEVEL_SCALE = 1'b0
   } reg_addr_type;

   typedef struct packed {
      logic                           tile_present;
      logic signed [COORD_BITS-1:0]   corner_a_x;
      logic signed [COORD_BITS-1:0]   corner_a_y;
      logic signed [COORD_BITS-1:0]   corner_a_z;
      logic signed [COORD_BITS-1:0]   corner_b_x;
      logic signed [COORD_BITS-1:0]   corner_b_y;
      logic signed [COORD_BITS-1:0]   corner_b_z;
      logic signed [COORD_BITS-1:0]   corner_c_x;
      logic signed [COORD_BITS-1:0]   corner_c_y;
      logic signed [COORD_BITS-1:0]   corner_c_z;
      logic signed [31:0]             query_x;
      logic signed [31:0]             query_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0]    height;
      logic                  ok;
   } rsp_type;

   // state carried along the divider chain
   typedef struct packed {
      logic                  neg;
      logic                  zero;
      logic [NUM_W-1:0]      rem;
      logic [NUM_W-1:0]      num;
      logic [DEN_W-1:0]      den;
      logic [QUO_W-1:0]      quo;
   } div_cell_type;

endpackage

FILE: rtl/core/tph_div_cell.sv
`timescale 1ns / 1ps
module tph_div_cell
   import tph_pkg::*;
#(
   parameter int BIT_POS = 0
) (
   input  logic         clock,
   input  logic         advance,
   input  div_cell_type cell_in,
   output div_cell_type cell_out
);

   div_cell_type cell_ff, cell_next_in;
   logic [NUM_W:0] shifted;
   logic [NUM_W:0] diff;

   // one restoring step: bring down numerator bit BIT_POS
   always_comb begin
      cell_next_in = cell_in;
      shifted = {cell_in.rem, cell_in.num[BIT_POS]};
      diff = shifted - {{(NUM_W+1-DEN_W){1'b0}}, cell_in.den};
      if (!diff[NUM_W]) begin
         cell_next_in.rem = diff[NUM_W-1:0];
         cell_next_in.quo[BIT_POS] = 1'b1;
      end else begin
         cell_next_in.rem = shifted[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_next_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

FILE: rtl/core/tph_front.sv
`timescale 1ns / 1ps
module tph_front
   import tph_pkg::*;
(
   input  logic                clock,
   input  logic                advance,
   input  req_type             req,
   input  logic [SCALE_W-1:0]  scale,
   output div_cell_type        cell_out
);

   localparam int PH_W   = DQ_W - SPLIT_W + NORM_W;
   localparam int PL_W   = SPLIT_W + 1 + NORM_W;
   localparam int PA_W   = COORD_BITS + NORM_W + QW + 1;
   localparam int FLAT_W = COORD_BITS + QW + 1;

   // stage 1: edges, scaled query
   logic                       s1_bad_ff;
   logic signed [EDGE_W-1:0]   abx_ff, aby_ff, abz_ff, acx_ff, acy_ff, acz_ff;
   logic signed [DQ_W-1:0]     dx_ff, dz_ff;
   logic signed [COORD_BITS-1:0] ay1_ff;
   logic [SCALE_W-1:0]         l1_ff;
   // stage 2: normal
   logic                       s2_bad_ff;
   logic signed [NORM_W-1:0]   nx_ff, ny_ff, nz_ff;
   logic signed [DQ_W-1:0]     dx2_ff, dz2_ff;
   logic signed [COORD_BITS-1:0] ay2_ff;
   logic [SCALE_W-1:0]         l2_ff;
   // stage 3: partial products
   logic                       s3_bad_ff, s3_flat_ff;
   logic signed [PH_W-1:0]     pxh_ff, pzh_ff;
   logic signed [PL_W-1:0]     pxl_ff, pzl_ff;
   logic signed [PA_W-1:0]     pa_ff;
   logic signed [DEN_W-1:0]    den3_ff;
   logic signed [FLAT_W-1:0]   flat3_ff;
   logic [SCALE_W-1:0]         l3_ff;
   // stage 4: numerator sum
   logic                       s4_bad_ff, s4_flat_ff;
   logic signed [NUM_W-1:0]    num4_ff;
   logic signed [DEN_W-1:0]    den4_ff;
   logic signed [FLAT_W-1:0]   flat4_ff;
   logic [SCALE_W-1:0]         l4_ff;

   logic signed [NUM_W-1:0] num_w;
   logic signed [DEN_W-1:0] den_w;
   div_cell_type head_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_bad_ff  <= !req.tile_present || (scale == '0);
         abx_ff <= EDGE_W'(req.corner_b_x) - EDGE_W'(req.corner_a_x);
         aby_ff <= EDGE_W'(req.corner_b_y) - EDGE_W'(req.corner_a_y);
         abz_ff <= EDGE_W'(req.corner_b_z) - EDGE_W'(req.corner_a_z);
         acx_ff <= EDGE_W'(req.corner_c_x) - EDGE_W'(req.corner_a_x);
         acy_ff <= EDGE_W'(req.corner_c_y) - EDGE_W'(req.corner_a_y);
         acz_ff <= EDGE_W'(req.corner_c_z) - EDGE_W'(req.corner_a_z);
         dx_ff <= DQ_W'(req.query_x) * DQ_W'($signed({1'b0, scale}))
                  - (DQ_W'(req.corner_a_x) <<< QW);
         dz_ff <= DQ_W'(req.query_z) * DQ_W'($signed({1'b0, scale}))
                  - (DQ_W'(req.corner_a_z) <<< QW);
         ay1_ff <= req.corner_a_y;
         l1_ff  <= scale;

         s2_bad_ff  <= s1_bad_ff;
         nx_ff <= NORM_W'(aby_ff) * NORM_W'(acz_ff) - NORM_W'(abz_ff) * NORM_W'(acy_ff);
         ny_ff <= NORM_W'(abz_ff) * NORM_W'(acx_ff) - NORM_W'(abx_ff) * NORM_W'(acz_ff);
         nz_ff <= NORM_W'(abx_ff) * NORM_W'(acy_ff) - NORM_W'(aby_ff) * NORM_W'(acx_ff);
         dx2_ff <= dx_ff;
         dz2_ff <= dz_ff;
         ay2_ff <= ay1_ff;
         l2_ff  <= l1_ff;

         // offset times normal as signed upper half and unsigned lower half
         s3_bad_ff  <= s2_bad_ff;
         s3_flat_ff <= (ny_ff == '0);
         pxh_ff  <= PH_W'($signed(dx2_ff[DQ_W-1:SPLIT_W])) * PH_W'(nx_ff);
         pxl_ff  <= PL_W'($signed({1'b0, dx2_ff[SPLIT_W-1:0]})) * PL_W'(nx_ff);
         pzh_ff  <= PH_W'($signed(dz2_ff[DQ_W-1:SPLIT_W])) * PH_W'(nz_ff);
         pzl_ff  <= PL_W'($signed({1'b0, dz2_ff[SPLIT_W-1:0]})) * PL_W'(nz_ff);
         pa_ff   <= (PA_W'(ay2_ff) * PA_W'(ny_ff)) <<< QW;
         den3_ff <= DEN_W'(ny_ff) * DEN_W'($signed({1'b0, l2_ff}));
         flat3_ff <= FLAT_W'(ay2_ff) <<< QW;
         l3_ff   <= l2_ff;

         s4_bad_ff  <= s3_bad_ff;
         s4_flat_ff <= s3_flat_ff;
         num4_ff <= NUM_W'(pa_ff)
                    - ((NUM_W'(pxh_ff) <<< SPLIT_W) + NUM_W'(pxl_ff))
                    - ((NUM_W'(pzh_ff) <<< SPLIT_W) + NUM_W'(pzl_ff));
         den4_ff  <= den3_ff;
         flat4_ff <= flat3_ff;
         l4_ff    <= l3_ff;
      end
   end

   // signed numerator and denominator, then magnitudes for the divider
   always_comb begin
      if (s4_flat_ff) begin
         num_w = NUM_W'(flat4_ff);
         den_w = DEN_W'($signed({1'b0, l4_ff}));
      end else begin
         num_w = num4_ff;
         den_w = den4_ff;
      end
      head_in.zero = s4_bad_ff;
      head_in.neg  = num_w[NUM_W-1] ^ den_w[DEN_W-1];
      head_in.num  = num_w[NUM_W-1] ? NUM_W'(-num_w) : NUM_W'(num_w);
      head_in.den  = den_w[DEN_W-1] ? DEN_W'(-den_w) : DEN_W'(den_w);
      head_in.rem  = '0;
      head_in.quo  = '0;
   end

   assign cell_out = head_in;

endmodule

FILE: rtl/core/triangle_plane_height.sv
`timescale 1ns / 1ps
// channel | direction | signals
// req     | in        | req_valid, req_ready, req_data (req_type)
// rsp     | out       | rsp_valid, rsp_ready, rsp_data (rsp_type)
// csr     | in/out    | csr_psel/penable/pwrite/paddr/pwdata/prdata/pready
// one item per cycle unless the output stalls; the pipe is 4 front stages, one restoring
// divider cell per numerator bit (94 cells), and an output register.
// a stalled output freezes the whole chain; req_ready follows rsp side.
// reset clears valid flags and level_scale to 1.0.
module triangle_plane_height
   import tph_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [SCALE_W-1:0] scale_ff;
   logic               advance;
   logic               out_valid_ff;
   rsp_type            out_ff, out_in;
   div_cell_type       chain [NUM_W+1];
   logic [NUM_W+3:0]   live_ff;
   div_cell_type       tail;
   logic [QUO_W-1:0]   q;

   // config register
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_W'(65536);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   reg_addr_type'(csr_paddr[2]) == REG_LEVEL_SCALE) begin
         scale_ff <= csr_pwdata[SCALE_W-1:0];
      end
   end
   assign csr_prdata = (reg_addr_type'(csr_paddr[2]) == REG_LEVEL_SCALE) ?
                       {8'd0, scale_ff} : 32'd0;

   // whole pipe moves unless a held result blocks it
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   tph_front u_front (
      .clock    (clock),
      .advance  (advance),
      .req      (req_data),
      .scale    (scale_ff),
      .cell_out (chain[0])
   );

   // divider cells, msb first
   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      tph_div_cell #(.BIT_POS(NUM_W-1-i)) u_cell (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // valid flags along the pipe, reset-cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (advance) begin
         live_ff <= {live_ff[NUM_W+2:0], req_valid};
      end
   end

   assign tail = chain[NUM_W];
   assign q = tail.quo;

   // saturate and format
   always_comb begin
      out_in.ok = 1'b1;
      if (tail.zero) begin
         out_in.height = '0;
         out_in.ok     = 1'b0;
      end else if (tail.neg) begin
         if (q > QUO_W'(33'h80000000)) begin
            out_in.height = 32'sh80000000;
            out_in.ok     = 1'b0;
         end else begin
            out_in.height = 32'(-q);
         end
      end else begin
         if (q > QUO_W'(32'h7fffffff)) begin
            out_in.height = 32'sh7fffffff;
            out_in.ok     = 1'b0;
         end else begin
            out_in.height = q[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= live_ff[NUM_W+3];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
